/* hdl/ssce_pkg.sv */
package ssce_pkg;

    localparam int STATE_BITS  = 8;
    localparam int INPUT_BITS  = 4;
    localparam int OUTPUT_BITS = 8;

    localparam int SYMBOL_W = 4;
    localparam int LOAD_W   = 8;
    localparam int CODE_W   = 8;
    localparam int NOW_W    = 8;

    localparam int A_W = STATE_BITS * STATE_BITS;
    localparam int B_W = STATE_BITS * INPUT_BITS;
    localparam int C_W = OUTPUT_BITS * STATE_BITS;
    localparam int D_W = OUTPUT_BITS * INPUT_BITS;

    localparam int DATA_W = 64;
    localparam int ADDR_W = 5;
    localparam int IDX_W  = 2;

    localparam logic [IDX_W-1:0] REG_A = 2'd0;
    localparam logic [IDX_W-1:0] REG_B = 2'd1;
    localparam logic [IDX_W-1:0] REG_C = 2'd2;
    localparam logic [IDX_W-1:0] REG_D = 2'd3;

    localparam logic CMD_ENCODE = 1'b0;
    localparam logic CMD_LOAD   = 1'b1;

    typedef struct packed {
        logic                  is_load;
        logic [INPUT_BITS-1:0] symbol;
        logic [STATE_BITS-1:0] load_value;
    } t_op;

    typedef struct packed {
        logic [A_W-1:0] a;
        logic [B_W-1:0] b;
        logic [C_W-1:0] c;
        logic [D_W-1:0] d;
    } t_cfg;

    function automatic logic [STATE_BITS-1:0] f_next_state(
        t_cfg                  cfg,
        logic [STATE_BITS-1:0] x,
        logic [INPUT_BITS-1:0] u
    );
        logic [STATE_BITS-1:0] res;
        res = '0;
        for (int i = 0; i < STATE_BITS; i++) begin
            res[i] = (^(cfg.a[i*STATE_BITS +: STATE_BITS] & x))
                   ^ (^(cfg.b[i*INPUT_BITS +: INPUT_BITS] & u));
        end
        return res;
    endfunction

    function automatic logic [OUTPUT_BITS-1:0] f_code_word(
        t_cfg                  cfg,
        logic [STATE_BITS-1:0] x,
        logic [INPUT_BITS-1:0] u
    );
        logic [OUTPUT_BITS-1:0] res;
        res = '0;
        for (int i = 0; i < OUTPUT_BITS; i++) begin
            res[i] = (^(cfg.c[i*STATE_BITS +: STATE_BITS] & x))
                   ^ (^(cfg.d[i*INPUT_BITS +: INPUT_BITS] & u));
        end
        return res;
    endfunction

endpackage

/* hdl/state_space_convolutional_encoder_unit.sv */
// Channel   Direction  Handshake          Payload
// input     in         i_valid / o_ready  i_command, i_symbol_in, i_load_value
// result    out        o_valid / i_ready  o_code_word, o_state_now
// config    in         APB psel/penable   paddr, pwdata, prdata (64-bit data bus)
//
// One word per cycle is sustained unless the result stalls; an accepted word passes
// from the input register through the queue into the result register on the output.
// Reset is synchronous and clears the matrices, the state and all valid flags.
// A stalled result register holds the queue, and a full queue stalls the input.
module state_space_convolutional_encoder_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_command,
    input  logic [ssce_pkg::SYMBOL_W-1:0] i_symbol_in,
    input  logic [ssce_pkg::LOAD_W-1:0]  i_load_value,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [ssce_pkg::CODE_W-1:0]  o_code_word,
    output logic [ssce_pkg::NOW_W-1:0]   o_state_now,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ssce_pkg::ADDR_W-1:0]  paddr,
    input  logic [ssce_pkg::DATA_W-1:0]  pwdata,
    output logic [ssce_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);
    import ssce_pkg::*;

    t_cfg w_cfg;
    t_op  w_front_op;
    t_op  w_queue_op;
    logic w_push;
    logic w_q_ready;
    logic w_q_valid;
    logic w_pop;

    ssce_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    ssce_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_command    (i_command),
        .i_symbol_in  (i_symbol_in),
        .i_load_value (i_load_value),
        .o_push       (w_push),
        .o_op         (w_front_op),
        .i_q_ready    (w_q_ready)
    );

    ssce_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_op    (w_front_op),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .o_op    (w_queue_op),
        .i_pop   (w_pop)
    );

    ssce_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_q_valid   (w_q_valid),
        .i_op        (w_queue_op),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_code_word (o_code_word),
        .o_state_now (o_state_now)
    );

endmodule

/* hdl/ssce_cfg.sv */
module ssce_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ssce_pkg::ADDR_W-1:0]  paddr,
    input  logic [ssce_pkg::DATA_W-1:0]  pwdata,
    output logic [ssce_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output ssce_pkg::t_cfg               o_cfg
);
    import ssce_pkg::*;

    logic [A_W-1:0]   r_a;
    logic [B_W-1:0]   r_b;
    logic [C_W-1:0]   r_c;
    logic [D_W-1:0]   r_d;
    logic [IDX_W-1:0] w_index;
    logic             w_write;

    assign pready  = 1'b1;
    assign w_index = paddr[ADDR_W-1 -: IDX_W];
    assign w_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a <= '0;
            r_b <= '0;
            r_c <= '0;
            r_d <= '0;
        end else if (w_write) begin
            case (w_index)
                REG_A:   r_a <= pwdata[A_W-1:0];
                REG_B:   r_b <= pwdata[B_W-1:0];
                REG_C:   r_c <= pwdata[C_W-1:0];
                REG_D:   r_d <= pwdata[D_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (w_index)
            REG_A:   prdata = DATA_W'(r_a);
            REG_B:   prdata = DATA_W'(r_b);
            REG_C:   prdata = DATA_W'(r_c);
            REG_D:   prdata = DATA_W'(r_d);
            default: prdata = '0;
        endcase
    end

    assign o_cfg = '{a: r_a, b: r_b, c: r_c, d: r_d};

endmodule

/* hdl/ssce_front.sv */
module ssce_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_command,
    input  logic [ssce_pkg::SYMBOL_W-1:0] i_symbol_in,
    input  logic [ssce_pkg::LOAD_W-1:0]   i_load_value,
    output logic                          o_push,
    output ssce_pkg::t_op                 o_op,
    input  logic                          i_q_ready
);
    import ssce_pkg::*;

    logic r_valid;
    t_op  r_op;
    t_op  n_op;
    logic w_take;

    assign o_ready = !r_valid || i_q_ready;
    assign w_take  = i_valid && o_ready;

    always_comb begin
        n_op.is_load    = (i_command == CMD_LOAD);
        n_op.symbol     = i_symbol_in[INPUT_BITS-1:0];
        n_op.load_value = i_load_value[STATE_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_op <= n_op;
        end
    end

    assign o_push = r_valid;
    assign o_op   = r_op;

endmodule

/* hdl/ssce_queue.sv */
module ssce_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ssce_pkg::t_op i_op,
    output logic          o_ready,
    output logic          o_valid,
    output ssce_pkg::t_op o_op,
    input  logic          i_pop
);
    import ssce_pkg::*;

    t_op        r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       w_wr;
    logic       w_rd;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign w_wr    = i_push && o_ready;
    assign w_rd    = i_pop && o_valid;
    assign o_op    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_rd) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + 2'(w_wr) - 2'(w_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("queue count out of range");

    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wr && !w_rd && r_count == 2'd1) |=> !o_ready)
        else $error("queue did not report full");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_rd && !w_wr && r_count == 2'd1) |=> !o_valid)
        else $error("queue did not report empty");

endmodule

/* hdl/ssce_back.sv */
module ssce_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ssce_pkg::t_cfg              i_cfg,
    input  logic                        i_q_valid,
    input  ssce_pkg::t_op               i_op,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [ssce_pkg::CODE_W-1:0] o_code_word,
    output logic [ssce_pkg::NOW_W-1:0]  o_state_now
);
    import ssce_pkg::*;

    logic [STATE_BITS-1:0]  r_state;
    logic [STATE_BITS-1:0]  n_state;
    logic [OUTPUT_BITS-1:0] r_code_word;
    logic [OUTPUT_BITS-1:0] n_code_word;
    logic                   r_out_valid;

    assign o_pop = i_q_valid && (!r_out_valid || i_ready);

    always_comb begin
        if (i_op.is_load) begin
            n_state     = i_op.load_value;
            n_code_word = '0;
        end else begin
            n_state     = f_next_state(i_cfg, r_state, i_op.symbol);
            n_code_word = f_code_word(i_cfg, r_state, i_op.symbol);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_code_word <= n_code_word;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_code_word = CODE_W'(r_code_word);
    assign o_state_now = NOW_W'(r_state);

    a_load_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_op.is_load) |=> (r_state == $past(i_op.load_value)))
        else $error("load did not set the state");

    a_load_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_op.is_load) |=> (r_code_word == '0))
        else $error("load word carries a nonzero code word");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> ($stable(r_state) && r_out_valid))
        else $error("state moved while a result was stalled");

endmodule
